// ----- rtl/bwhc_pkg.sv -----
// Shared types and constants for the bucketed window hit counter.
// No dependencies; imported by the front, queue, back and top modules.
package bwhc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned TotalW = 40;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic {
    FUNC_HIT   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [TimeW-1:0]  now;
  } bwhc_cmd_t;

  typedef struct packed {
    logic [TimeW-1:0]  stamp;
    logic [CountW-1:0] count;
  } bwhc_bucket_t;

  typedef struct packed {
    logic clearing;
    logic query_busy;
  } bwhc_status_t;

endpackage

// ----- rtl/bucketed_window_hit_counter_unit.sv -----
// Bucketed sliding-window hit counter, top level. Depends on bwhc_pkg, bwhc_front,
// bwhc_fifo and bwhc_back. Front: accepts a transaction, reduces a hit's time mod
// WINDOW, then pushes it to the queue. Back: a hit is a bucket RAM read-modify-write; a
// query sweeps all WINDOW buckets before its result is presented. The front takes a new
// hit only once the last one is being pushed. Reset: synchronous; a clearing pass zeroes
// the RAM and holds in_stall high meanwhile.
module bucketed_window_hit_counter_unit import bwhc_pkg::*; #(
  parameter int unsigned WINDOW = 300
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [TimeW-1:0]  now_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TotalW-1:0] hit_count
);

  localparam int unsigned AW = $clog2(WINDOW);

  bwhc_status_t  status;
  logic          q_push;
  bwhc_cmd_t     push_cmd;
  logic [AW-1:0] push_idx;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  bwhc_cmd_t     head_cmd;
  logic [AW-1:0] head_idx;

  bwhc_front #(
    .WINDOW(WINDOW),
    .AW    (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .now_seconds(now_seconds),
    .status     (status),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_idx      (push_idx)
  );

  bwhc_fifo #(
    .AW(AW)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .push_idx(push_idx),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head_cmd(head_cmd),
    .head_idx(head_idx)
  );

  bwhc_back #(
    .WINDOW(WINDOW),
    .AW    (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (head_cmd),
    .q_idx    (head_idx),
    .q_pop    (q_pop),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit_count(hit_count)
  );

endmodule

// ----- rtl/bwhc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bwhc_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 300,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bwhc_fifo.sv -----
// Two-entry command queue between the front and back parts.
// Depends on bwhc_pkg for the command type.
module bwhc_fifo import bwhc_pkg::*; #(
  parameter int unsigned AW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bwhc_cmd_t     push_cmd,
  input  logic [AW-1:0] push_idx,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output bwhc_cmd_t     head_cmd,
  output logic [AW-1:0] head_idx
);

  bwhc_cmd_t     mem_cmd [2];
  logic [AW-1:0] mem_idx [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign head_cmd = mem_cmd[rd_ptr];
  assign head_idx = mem_idx[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        mem_cmd[wr_ptr] <= push_cmd;
        mem_idx[wr_ptr] <= push_idx;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/bwhc_front.sv -----
// Front part: accepts transactions and derives the bucket index (time mod WINDOW)
// eight bits per cycle. Depends on bwhc_pkg; feeds bwhc_fifo.
module bwhc_front import bwhc_pkg::*; #(
  parameter int unsigned WINDOW = 300,
  parameter int unsigned AW     = $clog2(WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             func,
  input  logic [TimeW-1:0] now_seconds,
  input  bwhc_status_t     status,
  input  logic             q_full,
  output logic             q_push,
  output bwhc_cmd_t        q_cmd,
  output logic [AW-1:0]    q_idx
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } fstate_t;

  fstate_t          state;
  bwhc_cmd_t        cmd;
  logic [TimeW-1:0] sh;
  logic [AW-1:0]    rem;
  logic [AW-1:0]    rem_next;
  logic [1:0]       step_cnt;
  logic             accept;

  assign q_push   = (state == F_PUSH) && !q_full;
  assign in_stall = status.clearing || !((state == F_IDLE) || q_push);
  assign accept   = in_valid && !in_stall;
  assign q_cmd    = cmd;
  assign q_idx    = rem;

  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, sh[TimeW-1-i]};
      if (t >= (AW+1)'(WINDOW)) begin
        t = t - (AW+1)'(WINDOW);
      end
      r = t[AW-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      step_cnt <= 2'd0;
    end else if (accept) begin
      cmd      <= '{func: func_t'(func), now: now_seconds};
      sh       <= now_seconds;
      rem      <= '0;
      step_cnt <= 2'd0;
      state    <= (func_t'(func) == FUNC_QUERY) ? F_PUSH : F_MOD;
    end else begin
      case (state)
        F_MOD: begin
          rem      <= rem_next;
          sh       <= sh << 8;
          step_cnt <= step_cnt + 2'd1;
          if (step_cnt == 2'd3) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bwhc_back.sv -----
// Back part: clears the bucket RAM after reset, applies hits by read-modify-write
// and sweeps all buckets for queries. Depends on bwhc_pkg and bwhc_ram.
module bwhc_back import bwhc_pkg::*; #(
  parameter int unsigned WINDOW = 300,
  parameter int unsigned AW     = $clog2(WINDOW)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  bwhc_cmd_t         q_cmd,
  input  logic [AW-1:0]     q_idx,
  output logic              q_pop,
  output bwhc_status_t      status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TotalW-1:0] hit_count
);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HIT_WR,
    B_Q_RUN,
    B_Q_DRAIN,
    B_Q_OUT
  } bstate_t;

  localparam logic [AW-1:0]    LastAddr = AW'(WINDOW - 1);
  localparam logic [TimeW-1:0] WinTime  = TimeW'(WINDOW);

  bstate_t           state;
  logic [AW-1:0]     addr;
  bwhc_cmd_t         cur;
  logic [TotalW-1:0] total;
  logic              acc_en;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  bwhc_bucket_t      wdata;
  bwhc_bucket_t      rd;
  bwhc_bucket_t      upd;
  logic [TimeW-1:0]  age;
  logic [CountW-1:0] add;
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] total_next;
  logic              out_free;

  bwhc_ram #(
    .WIDTH ($bits(bwhc_bucket_t)),
    .DEPTH (WINDOW),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rd)
  );

  assign q_pop             = (state == B_IDLE) && !q_empty;
  assign re                = (q_pop && (q_cmd.func == FUNC_HIT)) || (state == B_Q_RUN);
  assign raddr             = (state == B_Q_RUN) ? addr : q_idx;
  assign we                = (state == B_CLEAR) || (state == B_HIT_WR);
  assign status.clearing   = (state == B_CLEAR);
  assign status.query_busy = (state == B_Q_RUN) || (state == B_Q_DRAIN) || (state == B_Q_OUT);
  assign out_free          = !out_valid || !out_stall;
  assign age               = cur.now - rd.stamp;

  always_comb begin
    upd.stamp = cur.now;
    if (age >= WinTime) begin
      upd.count = CountW'(1);
    end else if (rd.count == CountMax) begin
      upd.count = rd.count;
    end else begin
      upd.count = rd.count + CountW'(1);
    end
    wdata = (state == B_CLEAR) ? '0 : upd;
  end

  always_comb begin
    add        = (acc_en && (age < WinTime)) ? rd.count : '0;
    sum        = {1'b0, total} + (TotalW+1)'(add);
    total_next = (sum > {1'b0, TotalMax}) ? TotalMax : sum[TotalW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      addr      <= '0;
      acc_en    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc_en <= (state == B_Q_RUN);
      if (acc_en) begin
        total <= total_next;
      end
      if ((state == B_Q_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          if (addr == LastAddr) begin
            addr  <= '0;
            state <= B_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            cur <= q_cmd;
            if (q_cmd.func == FUNC_HIT) begin
              addr  <= q_idx;
              state <= B_HIT_WR;
            end else begin
              addr  <= '0;
              total <= '0;
              state <= B_Q_RUN;
            end
          end
        end
        B_HIT_WR: begin
          state <= B_IDLE;
        end
        B_Q_RUN: begin
          addr <= addr + AW'(1);
          if (addr == LastAddr) begin
            state <= B_Q_DRAIN;
          end
        end
        B_Q_DRAIN: begin
          state <= B_Q_OUT;
        end
        B_Q_OUT: begin
          if (out_free) begin
            hit_count <= total;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == B_CLEAR)
    else $error("bucket clearing pass did not start after reset");

  a_hit_follows_pop: assert property (@(posedge clk) disable iff (rst)
    state == B_HIT_WR |-> $past(state) == B_IDLE && $past(q_pop))
    else $error("hit write without a popped command");

  a_sweep_no_write: assert property (@(posedge clk) disable iff (rst)
    state == B_Q_RUN || state == B_Q_DRAIN |-> !we)
    else $error("bucket write during query sweep");

  a_acc_window: assert property (@(posedge clk) disable iff (rst)
    acc_en |-> state == B_Q_RUN || state == B_Q_DRAIN)
    else $error("accumulate outside query sweep");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !q_pop && !out_valid)
    else $error("command taken during clearing pass");

endmodule

// ----- dv/tb_bucketed_window_hit_counter_unit.sv -----
// Testbench for bucketed_window_hit_counter_unit: directed window and wraparound cases,
// random hit/query traffic with idling on both channels, and a long output hold-off.
// Depends on bwhc_pkg and the unit's RTL; predicts every window total in its own model.
`timescale 1ns / 1ps

module tb_bucketed_window_hit_counter_unit;
  import bwhc_pkg::*;

  localparam int unsigned WINDOW          = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned QUERY_PCT       = 15;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [TimeW-1:0]  now_seconds;
  logic              out_valid;
  logic              out_stall;
  logic [TotalW-1:0] hit_count;

  // Shadow bucket store
  logic [TimeW-1:0]  shadow_stamp [WINDOW];
  logic [CountW-1:0] shadow_hits  [WINDOW];
  logic [TotalW-1:0] pending_totals [$];

  bit                tx_gaps_on;
  bit                rx_stall_on;
  bit                hold_off_req;
  int unsigned       fail_count;
  int unsigned       hits_sent;
  int unsigned       queries_sent;
  int unsigned       totals_checked;
  int unsigned       time_setbacks;
  logic [TimeW-1:0]  last_time;
  logic [TotalW-1:0] want_total;

  bucketed_window_hit_counter_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .now_seconds(now_seconds),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit_count  (hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void log_hit(logic [TimeW-1:0] t);
    int unsigned      b;
    logic [TimeW-1:0] age;
    b   = t % WINDOW;
    age = t - shadow_stamp[b];
    if (age >= WINDOW) begin
      shadow_hits[b] = 1;
    end else if (shadow_hits[b] != CountMax) begin
      shadow_hits[b] = shadow_hits[b] + 1'b1;
    end
    shadow_stamp[b] = t;
  endfunction

  function automatic logic [TotalW-1:0] window_total(logic [TimeW-1:0] t);
    logic [TotalW:0]  sum;
    logic [TimeW-1:0] age;
    sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      age = t - shadow_stamp[i];
      if (age < WINDOW) begin
        sum = sum + shadow_hits[i];
        if (sum > {1'b0, TotalMax}) begin
          sum = {1'b0, TotalMax};
        end
      end
    end
    return sum[TotalW-1:0];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [TimeW-1:0] next_time(logic [TimeW-1:0] cur);
    int unsigned r;
    r = $urandom_range(0, 999);
    if (r < 650) begin
      return cur;
    end else if (r < 900) begin
      return cur + $urandom_range(1, 3);
    end else if (r < 960) begin
      return cur + $urandom_range(4, WINDOW + 20);
    end else if (r < 985) begin
      return $urandom;
    end
    return cur - $urandom_range(1, WINDOW + 100);
  endfunction

  task automatic send_item(func_t f, logic [TimeW-1:0] t);
    int unsigned gap;
    in_valid    <= 1'b1;
    func        <= f;
    now_seconds <= t;
    do @(posedge clk); while (in_stall);
    if (t < last_time) begin
      time_setbacks++;
    end
    last_time = t;
    if (f == FUNC_HIT) begin
      log_hit(t);
      hits_sent++;
    end else begin
      pending_totals.push_back(window_total(t));
      queries_sent++;
    end
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_totals.size() != 0);
  endtask

  task automatic test_window_edges();
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    send_item(FUNC_QUERY, 32'd0);
    send_item(FUNC_QUERY, 32'hFFFF_FFFF);
    send_item(FUNC_HIT, 32'd5);
    send_item(FUNC_HIT, 32'd5);
    send_item(FUNC_HIT, 32'd6);
    send_item(FUNC_QUERY, 32'd6);
    send_item(FUNC_HIT, 32'd304);
    send_item(FUNC_HIT, 32'd305);
    send_item(FUNC_QUERY, 32'd305);
    send_item(FUNC_QUERY, 32'd604);
    send_item(FUNC_QUERY, 32'd605);
    drain_results();
  endtask

  task automatic test_wraparound();
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    send_item(FUNC_HIT, 32'hFFFF_FFFE);
    send_item(FUNC_HIT, 32'hFFFF_FFFF);
    send_item(FUNC_HIT, 32'd0);
    send_item(FUNC_HIT, 32'd1);
    send_item(FUNC_QUERY, 32'd2);
    send_item(FUNC_HIT, 32'd50);
    send_item(FUNC_QUERY, 32'd10);
    send_item(FUNC_HIT, 32'd600);
    send_item(FUNC_HIT, 32'd300);
    send_item(FUNC_QUERY, 32'd300);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [TimeW-1:0] t;
    func_t            f;
    for (int phase = 0; phase < 4; phase++) begin
      tx_gaps_on  = (phase == 0 || phase == 2);
      rx_stall_on = (phase == 0 || phase == 1);
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400) : $urandom;
      for (int i = 0; i < 440; i++) begin
        t = next_time(t);
        f = ($urandom_range(0, 99) < QUERY_PCT) ? FUNC_QUERY : FUNC_HIT;
        send_item(f, t);
      end
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    logic [TimeW-1:0] t;
    tx_gaps_on   = 1'b0;
    rx_stall_on  = 1'b0;
    hold_off_req = 1'b1;
    t = $urandom_range(1000, 1_000_000);
    for (int i = 0; i < 60; i++) begin
      t = t + $urandom_range(0, 1);
      send_item((i % 6 == 5) ? FUNC_QUERY : FUNC_HIT, t);
    end
    drain_results();
  endtask

  // Receiver: runs of ready and stalled cycles, plus one long hold-off on request
  initial begin
    int unsigned run;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        run = HOLD_OFF_CYCLES;
      end else if (rx_stall_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = idle_len();
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 24);
      end
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        $error("hit_count: no result expected, actual %0d", hit_count);
        fail_count++;
      end else begin
        want_total = pending_totals.pop_front();
        totals_checked++;
        if (hit_count !== want_total) begin
          $error("hit_count: expected %0d, actual %0d", want_total, hit_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= FUNC_HIT;
    now_seconds <= '0;
    last_time    = '0;
    for (int i = 0; i < WINDOW; i++) begin
      shadow_stamp[i] = '0;
      shadow_hits[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_window_edges();
    test_wraparound();
    test_random_traffic();
    test_backpressure();

    drain_results();
    repeat (WINDOW + 40) @(posedge clk);
    $display("Sent %0d hits and %0d window queries; %0d totals checked.",
             hits_sent, queries_sent, totals_checked);
    $display("Time stepped back or wrapped %0d times; one %0d-cycle output hold-off.",
             time_setbacks, HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bwhc_pkg.sv
rtl/bwhc_ram.sv
rtl/bwhc_fifo.sv
rtl/bwhc_front.sv
rtl/bwhc_back.sv
rtl/bucketed_window_hit_counter_unit.sv
dv/tb_bucketed_window_hit_counter_unit.sv
